/* rtl/tcw_pkg.sv */
// Package for the text console character writer: sizes, codes, item and control types.
`default_nettype none
package tcw_pkg;

  localparam int TEXT_ROWS = 32;
  localparam int TEXT_COLS = 128;
  localparam int DEPTH     = TEXT_ROWS * TEXT_COLS;
  localparam int ROW_W     = $clog2(TEXT_ROWS);
  localparam int COL_W     = $clog2(TEXT_COLS);
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;

  localparam int TAB_STEP = 4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [4:0] pos_row;
    logic [6:0] pos_col;
    logic       scrolled;
  } tcw_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep;
    logic sweep_row;
    logic base_adv;
    logic load_out;
  } tcw_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic scroll_req;
    logic clear_req;
    logic sweep_last;
    logic out_free;
  } tcw_stat_t;

  // physical cell address of a logical row/column through the ring row base
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] base,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0] s;
    s = {1'b0, base} + {1'b0, row};
    if (32'(s) >= TEXT_ROWS) begin
      s = s - (ROW_W+1)'(TEXT_ROWS);
    end
    return ADDR_W'(32'(s) * TEXT_COLS + 32'(col));
  endfunction

endpackage
`default_nettype wire

/* rtl/text_console_char_writer.sv */
// Top level of the text console character writer.
//
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one command item:
// put character, read cell or clear all. Output channel (out_valid_o/
// out_ready_i/out_item_o) returns exactly one result item per command, with
// the cell read (zero unless a read), the cursor afterwards and a scroll flag.
// One item is worked on at a time. After acceptance, a put or read without
// scroll goes straight to loading the result in the output register (a read
// goes through the store's registered read port); a put that scrolls first
// zeroes the old top row one cell a cycle through the store's write port,
// and a clear first zeroes every cell of the store, one cell a cycle.
// in_ready_o rises again the cycle after the load.
// After reset the store is zeroed one cell a cycle, during which in_ready_o
// stays low.
// The output register holds a finished result while the receiver stalls;
// the next item is still accepted, and its result waits until the output
// register is taken.
`default_nettype none
module text_console_char_writer import tcw_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire tcw_in_t in_item_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output tcw_out_t     out_item_o
);

  tcw_ctrl_t ctrl;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  tcw_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .ctrl_i     (ctrl),
    .stat_o     (stat)
  );

endmodule
`default_nettype wire

/* rtl/tcw_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/tcw_ctrl.sv */
// Controller state machine: accept, row/store clear sweeps, result hand-off.
`default_nettype none
module tcw_ctrl import tcw_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire tcw_stat_t stat_i,
  output tcw_ctrl_t      ctrl_o
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_ALL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    unique case (state_q)
      S_INIT: begin
        ctrl_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          if (stat_i.clear_req) begin
            state_d = S_ALL;
          end else if (stat_i.scroll_req) begin
            state_d = S_ROW;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_ROW: begin
        ctrl_o.sweep     = 1'b1;
        ctrl_o.sweep_row = 1'b1;
        if (stat_i.sweep_last) begin
          ctrl_o.base_adv = 1'b1;
          state_d         = S_FIN;
        end
      end
      S_ALL: begin
        ctrl_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/tcw_datapath.sv */
// Datapath: cursor and row base, character store, sweep counter, output register.
`default_nettype none
module tcw_datapath import tcw_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tcw_in_t   in_item_i,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output tcw_out_t       out_item_o,
  input  wire tcw_ctrl_t ctrl_i,
  output tcw_stat_t      stat_o
);

  localparam logic [ROW_W:0] ROWS_V = (ROW_W+1)'(TEXT_ROWS);
  localparam logic [COL_W:0] COLS_V = (COL_W+1)'(TEXT_COLS);

  logic [ROW_W-1:0]  row_q, base_q;
  logic [COL_W-1:0]  col_q;
  logic [ADDR_W-1:0] cnt_q;
  logic              scrolled_q, rd_ok_q, out_valid_q;
  tcw_out_t          out_q;

  logic [ROW_W:0]    nrow;
  logic [COL_W:0]    ncol, col_ext, col_inc, tab_col;
  logic [COL_W-1:0]  wcol;
  logic [7:0]        wdata;
  logic              put_we, is_put, scroll_req, rd_in_range;
  logic [31:0]       rrow_w, rcol_w, row_w, col_w;
  logic [ADDR_W-1:0] sweep_addr, waddr, raddr;
  logic              ram_we, ram_re;
  logic [7:0]        ram_wdata, ram_rdata;

  assign is_put  = in_item_i.cmd == CMD_PUT;
  assign col_ext = {1'b0, col_q};
  assign col_inc = col_ext + (COL_W+1)'(1);
  assign tab_col = (col_ext + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);

  always_comb begin
    nrow   = {1'b0, row_q};
    ncol   = col_ext;
    put_we = 1'b0;
    wcol   = col_q;
    wdata  = in_item_i.char_code;
    unique case (in_item_i.char_code)
      CH_NL: begin
        nrow = {1'b0, row_q} + (ROW_W+1)'(1);
        ncol = '0;
      end
      CH_CR: begin
        ncol = '0;
      end
      CH_TAB: begin
        if (tab_col >= COLS_V) begin
          ncol = '0;
          nrow = {1'b0, row_q} + (ROW_W+1)'(1);
        end else begin
          ncol = tab_col;
        end
      end
      CH_BS: begin
        if (col_q != '0) begin
          ncol   = col_ext - (COL_W+1)'(1);
          wcol   = col_q - COL_W'(1);
          wdata  = CH_SPACE;
          put_we = 1'b1;
        end
      end
      default: begin
        if (in_item_i.char_code >= CH_SPACE && in_item_i.char_code < CH_DEL) begin
          put_we = 1'b1;
          if (col_inc >= COLS_V) begin
            ncol = '0;
            nrow = {1'b0, row_q} + (ROW_W+1)'(1);
          end else begin
            ncol = col_inc;
          end
        end
      end
    endcase
  end

  assign scroll_req = is_put && (nrow == ROWS_V);

  assign rrow_w      = 32'(in_item_i.read_row);
  assign rcol_w      = 32'(in_item_i.read_col);
  assign rd_in_range = (rrow_w < TEXT_ROWS) && (rcol_w < TEXT_COLS);

  assign raddr = phys_addr(base_q, rrow_w[ROW_W-1:0], rcol_w[COL_W-1:0]);
  assign waddr = phys_addr(base_q, row_q, wcol);

  assign sweep_addr = ctrl_i.sweep_row ? ADDR_W'(32'(base_q) * TEXT_COLS + 32'(cnt_q))
                                       : cnt_q;

  assign ram_we    = ctrl_i.sweep || (ctrl_i.accept && is_put && put_we);
  assign ram_wdata = ctrl_i.sweep ? 8'd0 : wdata;
  assign ram_re    = ctrl_i.accept && (in_item_i.cmd == CMD_READ);

  tcw_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ctrl_i.sweep ? sweep_addr : waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  assign stat_o.scroll_req = scroll_req;
  assign stat_o.clear_req  = in_item_i.cmd == CMD_CLEAR;
  assign stat_o.sweep_last = ctrl_i.sweep_row ? (cnt_q == ADDR_W'(TEXT_COLS - 1))
                                              : (cnt_q == ADDR_W'(DEPTH - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      base_q     <= '0;
      cnt_q      <= '0;
      scrolled_q <= 1'b0;
      rd_ok_q    <= 1'b0;
    end else begin
      if (ctrl_i.accept) begin
        scrolled_q <= scroll_req;
        rd_ok_q    <= (in_item_i.cmd == CMD_READ) && rd_in_range;
        if (is_put) begin
          row_q <= scroll_req ? ROW_W'(TEXT_ROWS - 1) : nrow[ROW_W-1:0];
          col_q <= ncol[COL_W-1:0];
        end else if (in_item_i.cmd == CMD_CLEAR) begin
          row_q  <= '0;
          col_q  <= '0;
          base_q <= '0;
        end
      end
      if (ctrl_i.sweep) begin
        cnt_q <= stat_o.sweep_last ? '0 : cnt_q + ADDR_W'(1);
      end
      if (ctrl_i.base_adv) begin
        base_q <= (32'(base_q) == TEXT_ROWS - 1) ? '0 : base_q + ROW_W'(1);
      end
    end
  end

  assign row_w = 32'(row_q);
  assign col_w = 32'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_q.cell_char <= rd_ok_q ? ram_rdata : 8'd0;
      out_q.pos_row   <= row_w[4:0];
      out_q.pos_col   <= col_w[6:0];
      out_q.scrolled  <= scrolled_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

/* rtl/tcw_checker.sv */
// Port-level assertions for the text console character writer, bound to the top.
`default_nettype none
module tcw_port_checker import tcw_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire tcw_in_t  in_item_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire tcw_out_t out_item_o
);

  localparam logic [4:0] LAST_ROW = 5'(TEXT_ROWS - 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new item taken while one is in flight");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.scrolled |-> out_item_o.pos_row == LAST_ROW)
    else $error("scroll left cursor off the last row");

  a_cell_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.cell_char != 8'd0) |->
      (out_item_o.cell_char >= CH_SPACE) && (out_item_o.cell_char < CH_DEL) &&
      !out_item_o.scrolled)
    else $error("cell read returned a non-printable code");

endmodule

bind text_console_char_writer tcw_port_checker u_tcw_checker (.*);
`default_nettype wire

/* dv/tcw_checker.sv */
`timescale 1ns / 100ps
// Checker for the text console character writer: watches both channels, predicts and compares.
module tcw_checker import tcw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  tcw_in_t  in_item_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  tcw_out_t out_item_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       scroll_count_o
);

  logic [7:0]  screen_text [DEPTH];
  int unsigned pred_row;
  int unsigned pred_col;
  int unsigned ring_base;
  tcw_out_t    expected_results [$];
  tcw_out_t    oldest_result;

  function automatic int unsigned cell_index(int unsigned row, int unsigned col);
    return ((ring_base + row) % TEXT_ROWS) * TEXT_COLS + col;
  endfunction

  function automatic void blank_screen();
    for (int unsigned i = 0; i < DEPTH; i++) begin
      screen_text[i] = '0;
    end
    pred_row  = 0;
    pred_col  = 0;
    ring_base = 0;
  endfunction

  function automatic tcw_out_t console_step(tcw_in_t item);
    tcw_out_t    res;
    int unsigned code;
    res  = '0;
    code = 32'(item.char_code);
    case (item.cmd)
      CMD_PUT: begin
        if (code == 32'(CH_NL)) begin
          pred_row++;
          pred_col = 0;
        end else if (code == 32'(CH_CR)) begin
          pred_col = 0;
        end else if (code == 32'(CH_TAB)) begin
          pred_col = (pred_col + TAB_STEP) & ~(TAB_STEP - 1);
          if (pred_col >= TEXT_COLS) begin
            pred_col = 0;
            pred_row++;
          end
        end else if (code == 32'(CH_BS)) begin
          if (pred_col > 0) begin
            pred_col--;
            screen_text[cell_index(pred_row, pred_col)] = CH_SPACE;
          end
        end else if (code >= 32'(CH_SPACE) && code < 32'(CH_DEL)) begin
          screen_text[cell_index(pred_row, pred_col)] = item.char_code;
          pred_col++;
          if (pred_col >= TEXT_COLS) begin
            pred_col = 0;
            pred_row++;
          end
        end
        // ran off the bottom: old top row becomes the cleared bottom row
        if (pred_row >= TEXT_ROWS) begin
          for (int unsigned k = 0; k < TEXT_COLS; k++) begin
            screen_text[ring_base * TEXT_COLS + k] = '0;
          end
          ring_base    = (ring_base + 1) % TEXT_ROWS;
          pred_row     = TEXT_ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      CMD_READ: begin
        if (item.read_row < TEXT_ROWS && item.read_col < TEXT_COLS) begin
          res.cell_char = screen_text[cell_index(32'(item.read_row), 32'(item.read_col))];
        end
      end
      CMD_CLEAR: begin
        blank_screen();
      end
      default: begin
      end
    endcase
    res.pos_row = 5'(pred_row);
    res.pos_col = 7'(pred_col);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_screen();
      expected_results.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      scroll_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: cell_char %0d cursor %0d,%0d scrolled %0d",
                 out_item_i.cell_char, out_item_i.pos_row, out_item_i.pos_col,
                 out_item_i.scrolled);
          fail_count_o++;
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("cell_char", oldest_result.cell_char, out_item_i.cell_char);
          check_field("pos_row", 8'(oldest_result.pos_row), 8'(out_item_i.pos_row));
          check_field("pos_col", 8'(oldest_result.pos_col), 8'(out_item_i.pos_col));
          check_field("scrolled", 8'(oldest_result.scrolled), 8'(out_item_i.scrolled));
          if (out_item_i.scrolled === 1'b1) begin
            scroll_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(console_step(in_item_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the text console character writer: clock, reset, stimulus and verdict.
module tb_top;
  import tcw_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ACTIVE_TARGET = 800;
  localparam int QUIET_FROM    = 700;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 200;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tcw_in_t  in_item;
  logic     out_valid;
  logic     out_ready;
  tcw_out_t out_item;

  int fail_count;
  int pending;
  int scroll_count;
  int active_cnt;
  int put_cnt;
  int read_cnt;
  int clear_cnt;
  int unused_cnt;
  bit quiet;
  bit hold_req;
  bit held;

  text_console_char_writer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  tcw_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .scroll_count_o(scroll_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic bit is_active_code(logic [7:0] code);
    return code == CH_NL || code == CH_CR || code == CH_TAB || code == CH_BS ||
           (code >= CH_SPACE && code < CH_DEL);
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(CH_SPACE, CH_DEL - 1));
  endfunction

  task automatic issue(input logic [1:0] op, input logic [7:0] code,
                       input logic [4:0] row, input logic [6:0] col);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= '{cmd: op, char_code: code, read_row: row, read_col: col};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      CMD_PUT:   put_cnt++;
      CMD_READ:  read_cnt++;
      CMD_CLEAR: clear_cnt++;
      default:   unused_cnt++;
    endcase
    if (op == CMD_READ || op == CMD_CLEAR || (op == CMD_PUT && is_active_code(code))) begin
      active_cnt++;
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic put(input logic [7:0] code);
    issue(CMD_PUT, code, 5'($urandom), 7'($urandom));
  endtask

  task automatic peek(input logic [4:0] row, input logic [6:0] col);
    issue(CMD_READ, 8'($urandom), row, col);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic random_burst();
    int         kind;
    int         len;
    logic [7:0] code;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      len = $urandom_range(0, 12);
      repeat (len) put(printable());
      if ($urandom_range(0, 3) == 0) put(CH_CR);
      put(CH_NL);
    end else if (kind < 47) begin
      len = $urandom_range(5, 40);
      repeat (len) put(CH_NL);
    end else if (kind < 57) begin
      len = $urandom_range(20, 60);
      repeat (len) put($urandom_range(0, 1) ? CH_TAB : printable());
    end else if (kind < 75) begin
      len = $urandom_range(1, 4);
      repeat (len) peek(5'($urandom),
                        $urandom_range(0, 1) ? 7'($urandom_range(0, 23)) : 7'($urandom));
    end else if (kind < 85) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        case ($urandom_range(0, 3))
          0, 1:    put(CH_BS);
          2:       put(CH_CR);
          default: put(CH_TAB);
        endcase
      end
    end else if (kind < 95) begin
      len = $urandom_range(1, 4);
      repeat (len) begin
        if ($urandom_range(0, 1)) begin
          issue(CMD_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
        end else begin
          do code = 8'($urandom_range(0, 255)); while (is_active_code(code));
          put(code);
        end
      end
    end else if (kind < 97) begin
      issue(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    end else begin
      wait_drained();
    end
  endtask

  // result side: ready stretches, short stalls, and one long hold-off on request
  initial begin : result_sink
    int n;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = $urandom_range(1, 12);
        @(negedge clk);
        out_ready <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    in_valid   = 1'b0;
    in_item    = '0;
    rst_n      = 1'b0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    held       = 1'b0;
    active_cnt = 0;
    put_cnt    = 0;
    read_cnt   = 0;
    clear_cnt  = 0;
    unused_cnt = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset contents, field extremes, control codes, ignored codes
    peek(5'd0, 7'd0);
    peek(5'd31, 7'd127);
    put(8'd65);
    put(CH_DEL - 8'd1);
    put(CH_SPACE);
    put(CH_DEL);
    put(8'd255);
    put(8'd128);
    put(8'd0);
    put(CH_SPACE - 8'd1);
    put(CH_BS);
    peek(5'd0, 7'd2);
    put(CH_TAB);
    put(CH_CR);
    put(CH_BS);
    put(CH_NL);
    issue(CMD_UNUSED, 8'hff, 5'h1f, 7'h7f);
    peek(5'd0, 7'd0);
    peek(5'd0, 7'd1);
    issue(CMD_CLEAR, 8'hff, 5'h1f, 7'h7f);
    peek(5'd0, 7'd0);
    put(CH_TAB);
    issue(CMD_READ, 8'h00, 5'h00, 7'h00);

    while (active_cnt < ACTIVE_TARGET) begin
      if (active_cnt >= QUIET_FROM) quiet = 1'b1;
      if (!held && active_cnt >= HOLD_AT) begin
        // receiver stalls long while items keep coming, then a full drain
        held     = 1'b1;
        hold_req = 1'b1;
        quiet    = 1'b1;
        repeat (12) put(printable());
        quiet = 1'b0;
        wait_drained();
      end
      random_burst();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items: %0d put, %0d read, %0d clear, %0d unused command",
             put_cnt + read_cnt + clear_cnt + unused_cnt, put_cnt, read_cnt, clear_cnt,
             unused_cnt);
    $display("Results with a scroll: %0d, mismatches: %0d", scroll_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
